// ----- hdl/rmsvm_pkg.sv -----
// Package for the RMS volume meter: widths, item kinds, queue entry type.
// No dependencies; used by the front, back, top level and checker.
package rmsvm_pkg;

  // Default block length in samples
  localparam int BLOCK_SIZE_DEFAULT = 512;

  // Field widths
  localparam int WORD_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;   // square of a 16-bit signed value is at most 2^30
  localparam int VOL_W    = 8;

  // Volume scaling: root >> 3, saturated
  localparam int ROOT_SHIFT = 3;
  localparam int VOL_MAX    = 255;

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH = 4;

  // Item kinds, decided in the front part
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SAMPLE = 2'd0;  // plain sample, no result
  localparam kind_t KIND_LAST   = 2'd1;  // sample that closes the block
  localparam kind_t KIND_FAIL   = 2'd2;  // failed read: result zero, clear

  // One queue entry
  typedef struct packed {
    kind_t             kind;
    logic [SQ_W-1:0]   square;
  } entry_t;

endpackage

// ----- hdl/rmsvm_front.sv -----
// Front part of the RMS volume meter: takes input beats, squares the sample,
// classifies the beat and holds it in a short queue. Depends on rmsvm_pkg.
module rmsvm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rmsvm_pkg::WORD_W-1:0]  sample_word,
  input  logic                          last_of_block,
  input  logic                          read_failed,
  input  logic                          push,
  output logic                          full,
  output logic                          q_valid,
  output rmsvm_pkg::entry_t             q_entry,
  input  logic                          q_pop
);
  import rmsvm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic signed [SAMPLE_W-1:0]   sample;
  logic signed [2*SAMPLE_W-1:0] prod;
  entry_t                       in_entry;
  entry_t                       queue [QUEUE_DEPTH];
  logic [PW-1:0]                wr_ptr;
  logic [PW-1:0]                rd_ptr;
  logic [PW:0]                  fill;
  logic                         wr_en;
  logic                         rd_en;

  // Sample is the upper half of the word; its square is never negative
  assign sample = signed'(sample_word[WORD_W-1:WORD_W-SAMPLE_W]);
  assign prod   = sample * sample;

  // Classify: a failed read wins over the last mark
  always_comb begin
    in_entry.square = prod[SQ_W-1:0];
    priority if (read_failed) begin
      in_entry.kind = KIND_FAIL;
    end else if (last_of_block) begin
      in_entry.kind = KIND_LAST;
    end else begin
      in_entry.kind = KIND_SAMPLE;
    end
  end

  assign full    = (fill == (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_entry = queue[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= in_entry;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + (PW+1)'(1);
        2'b01:   fill <= fill - (PW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/rmsvm_back.sv -----
// Back part of the RMS volume meter: accumulates squares, then on block end
// runs a bit-serial divide and a bit-serial square root. Depends on rmsvm_pkg.
module rmsvm_back #(
  parameter int BLOCK_SIZE = rmsvm_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  rmsvm_pkg::entry_t            q_entry,
  output logic                         q_pop,
  output logic [rmsvm_pkg::VOL_W-1:0]  volume,
  output logic                         empty,
  input  logic                         pop
);
  import rmsvm_pkg::*;

  localparam int CW  = $clog2(BLOCK_SIZE + 1);   // sample count width
  localparam int SW  = SQ_W - 1 + CW;             // sum of squares width
  localparam int SQW = SW + (SW % 2);             // radicand width, even
  localparam int RW  = SQW / 2;                   // root width
  localparam int IW  = $clog2(SW);                // step counter width
  localparam int SAT_ROOT = (VOL_MAX + 1) << ROOT_SHIFT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;

  logic [1:0]      state;
  logic [SW-1:0]   sum;
  logic [CW-1:0]   count;
  logic [SW-1:0]   quo;
  logic [CW-1:0]   rem;
  logic [SQW-1:0]  rad;
  logic [RW:0]     srem;
  logic [RW-1:0]   root;
  logic [IW-1:0]   step;
  logic [VOL_W-1:0] vol;
  logic            res_valid;

  logic            out_free;
  logic            res_load;
  logic            room;
  logic [SW-1:0]   sum_acc;
  logic [CW-1:0]   count_acc;
  logic [CW:0]     div_sh;
  logic            div_ge;
  logic [CW:0]     div_diff;
  logic [RW+2:0]   sq_sh;
  logic [RW+2:0]   sq_trial;
  logic            sq_ge;
  logic [RW+2:0]   sq_diff;
  logic [RW-1:0]   root_fin;

  assign out_free = !res_valid || pop;
  assign volume   = vol;
  assign empty    = !res_valid;

  // Pop only when idle; block ends and failed reads need the result slot free
  assign q_pop = (state == ST_IDLE) && q_valid &&
                 ((q_entry.kind == KIND_SAMPLE) || out_free);

  // A result lands on a failed read or at the last root step
  assign res_load = (q_pop && (q_entry.kind == KIND_FAIL)) ||
                    ((state == ST_SQRT) && (step == '0));

  // Accumulate unless the block is already full
  assign room      = (count < CW'(BLOCK_SIZE));
  assign sum_acc   = room ? sum + SW'(q_entry.square) : sum;
  assign count_acc = room ? count + CW'(1) : count;

  // One restoring divide step
  assign div_sh   = {rem, quo[SW-1]};
  assign div_ge   = (div_sh >= {1'b0, count});
  assign div_diff = div_sh - {1'b0, count};

  // One square root step, two radicand bits at a time
  assign sq_sh    = {srem, rad[SQW-1:SQW-2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;
  assign root_fin = {root[RW-2:0], sq_ge};

  // Result slot: a new result wins over the pop of the old one
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop && res_valid) begin
      res_valid <= 1'b0;
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sum       <= '0;
      count     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (q_entry.kind)
              KIND_FAIL: begin
                sum       <= '0;
                count     <= '0;
                vol       <= '0;
              end
              KIND_LAST: begin
                count <= count_acc;
                quo   <= sum_acc;
                rem   <= '0;
                step  <= IW'(SW - 1);
                state <= ST_DIV;
              end
              default: begin
                sum   <= sum_acc;
                count <= count_acc;
              end
            endcase
          end
        end
        ST_DIV: begin
          rem  <= div_ge ? div_diff[CW-1:0] : div_sh[CW-1:0];
          quo  <= {quo[SW-2:0], div_ge};
          if (step == '0) begin
            // Zero count cannot occur, but would give a zero mean
            rad   <= (count == '0) ? '0 : SQW'({quo[SW-2:0], div_ge});
            srem  <= '0;
            root  <= '0;
            step  <= IW'(RW - 1);
            state <= ST_SQRT;
          end else begin
            step <= step - IW'(1);
          end
        end
        ST_SQRT: begin
          srem <= sq_ge ? sq_diff[RW:0] : sq_sh[RW:0];
          root <= root_fin;
          rad  <= rad << 2;
          step <= step - IW'(1);
          if (step == '0) begin
            vol       <= (root_fin >= RW'(SAT_ROOT)) ? VOL_W'(VOL_MAX)
                                                      : VOL_W'(root_fin >> ROOT_SHIFT);
            sum       <= '0;
            count     <= '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/rms_volume_meter_unit.sv -----
// Channel   | Ports                                          | Beat taken when
// ----------+------------------------------------------------+-----------------
// input     | sample_word, last_of_block, read_failed        | push && !full
// result    | volume                                         | pop && !empty
//
// The back part takes plain samples only while idle; a four-entry queue holds
// samples while the back part is busy. A block end runs the bit-serial divider
// and then the bit-serial root before the back part takes another entry.
// Reset is synchronous and empties the queue, the sums and the result slot.
// A waiting result stalls only block ends and failed reads, not samples.
//
// Top level of the RMS volume meter; depends on rmsvm_pkg, rmsvm_front and
// rmsvm_back.
module rms_volume_meter_unit #(
  parameter int BLOCK_SIZE = rmsvm_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rmsvm_pkg::WORD_W-1:0]  sample_word,
  input  logic                          last_of_block,
  input  logic                          read_failed,
  input  logic                          push,
  output logic                          full,
  output logic [rmsvm_pkg::VOL_W-1:0]   volume,
  output logic                          empty,
  input  logic                          pop
);
  import rmsvm_pkg::*;

  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  // Accept, square and queue
  rmsvm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_word   (sample_word),
    .last_of_block (last_of_block),
    .read_failed   (read_failed),
    .push          (push),
    .full          (full),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop)
  );

  // Accumulate, divide, root
  rmsvm_back #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .volume  (volume),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

// ----- hdl/rmsvm_check.sv -----
// Port-level checker for the RMS volume meter, bound to the top level.
// Depends on rmsvm_pkg for widths.
module rmsvm_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         push,
  input logic                         full,
  input logic [rmsvm_pkg::VOL_W-1:0]  volume,
  input logic                         empty,
  input logic                         pop
);
  import rmsvm_pkg::*;

  // Reset leaves no result and room in the queue
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("state after reset not empty");

  // A waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(volume)))
    else $error("result changed or vanished without a pop beat");

  // The result slot only empties through a pop beat
  a_empty_by_pop: assert property (@(posedge clk) disable iff (rst)
    ($rose(empty) && !$past(rst)) |-> $past(pop))
    else $error("result slot emptied without a pop");

  // The queue only fills through a push beat
  a_full_by_push: assert property (@(posedge clk) disable iff (rst)
    ($rose(full) && !$past(rst)) |-> $past(push))
    else $error("queue became full without a push");

endmodule

bind rms_volume_meter_unit rmsvm_check u_check (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .volume (volume),
  .empty  (empty),
  .pop    (pop)
);
